// File: hw/rtl/mbrs_pkg.sv
// Shared types, constants and helper functions for the Modbus ASCII register slave.
package mbrs_pkg;

    localparam logic [7:0] FC_READ     = 8'h03;
    localparam logic [7:0] FC_WRITE1   = 8'h06;
    localparam logic [7:0] FC_WRITEN   = 8'h10;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam int         WRITE_LIMIT = 47;
    localparam int         HDR_LEN     = 7;

    typedef enum logic [1:0] {
        RSP_NONE,
        RSP_READ,
        RSP_WR1,
        RSP_WRN
    } t_rsp;

    typedef enum logic [3:0] {
        D_NONE,
        D_RX,
        D_EVAL,
        D_FRD_HI,
        D_FRD_LO,
        D_NOTICE,
        D_COLON,
        D_FETCH,
        D_LOAD,
        D_LRC,
        D_HEX_HI,
        D_HEX_LO,
        D_CR,
        D_LF
    } t_dop;

    typedef struct packed {
        t_dop op;
    } t_cmd;

    typedef struct packed {
        logic frame_end;
        t_rsp rsp;
        logic out_free;
        logic bw_last;
        logic tx_last;
    } t_sts;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] d;
        if (v < 4'd10) begin
            d = 8'h30 + {4'd0, v};
        end else begin
            d = 8'h37 + {4'd0, v};
        end
        return d;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            r = {1'b1, t[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            r = {1'b1, t[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            r = {1'b1, t[3:0]};
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/mbrs_ram.sv
// Generic simple dual-port RAM with registered read.
module mbrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/mbrs_ctrl.sv
// Controller state machine: sequences request intake, frame evaluation and response output.
module mbrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  mbrs_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output mbrs_pkg::t_cmd o_cmd
);
    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_EVAL   = 13'b0000000000010,
        S_FRD_HI = 13'b0000000000100,
        S_FRD_LO = 13'b0000000001000,
        S_NOTICE = 13'b0000000010000,
        S_COLON  = 13'b0000000100000,
        S_FETCH  = 13'b0000001000000,
        S_LOAD   = 13'b0000010000000,
        S_HEX_HI = 13'b0000100000000,
        S_HEX_LO = 13'b0001000000000,
        S_LRC    = 13'b0010000000000,
        S_CR     = 13'b0100000000000,
        S_LF     = 13'b1000000000000
    } t_state;

    t_state         r_state, n_state;
    mbrs_pkg::t_rsp r_rsp, n_rsp;
    logic           r_lrc, n_lrc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rsp   <= mbrs_pkg::RSP_NONE;
            r_lrc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rsp   <= n_rsp;
            r_lrc   <= n_lrc;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_rsp      = r_rsp;
        n_lrc      = r_lrc;
        o_in_stall = 1'b1;
        o_cmd.op   = mbrs_pkg::D_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = mbrs_pkg::D_RX;
                    if (i_sts.frame_end) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                o_cmd.op = mbrs_pkg::D_EVAL;
                n_rsp    = i_sts.rsp;
                unique case (i_sts.rsp)
                    mbrs_pkg::RSP_READ: n_state = S_COLON;
                    mbrs_pkg::RSP_WR1:  n_state = S_NOTICE;
                    mbrs_pkg::RSP_WRN:  n_state = S_FRD_HI;
                    default:            n_state = S_IDLE;
                endcase
            end
            S_FRD_HI: begin
                o_cmd.op = mbrs_pkg::D_FRD_HI;
                n_state  = S_FRD_LO;
            end
            S_FRD_LO: begin
                o_cmd.op = mbrs_pkg::D_FRD_LO;
                n_state  = S_NOTICE;
            end
            S_NOTICE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = mbrs_pkg::D_NOTICE;
                    if (r_rsp == mbrs_pkg::RSP_WRN && !i_sts.bw_last) begin
                        n_state = S_FRD_HI;
                    end else begin
                        n_state = S_COLON;
                    end
                end
            end
            S_COLON: begin
                if (i_sts.out_free) begin
                    o_cmd.op = mbrs_pkg::D_COLON;
                    n_lrc    = 1'b0;
                    n_state  = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.op = mbrs_pkg::D_FETCH;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.op = mbrs_pkg::D_LOAD;
                n_state  = S_HEX_HI;
            end
            S_HEX_HI: begin
                if (i_sts.out_free) begin
                    o_cmd.op = mbrs_pkg::D_HEX_HI;
                    n_state  = S_HEX_LO;
                end
            end
            S_HEX_LO: begin
                if (i_sts.out_free) begin
                    o_cmd.op = mbrs_pkg::D_HEX_LO;
                    if (r_lrc) begin
                        n_state = S_CR;
                    end else if (i_sts.tx_last) begin
                        n_state = S_LRC;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_LRC: begin
                o_cmd.op = mbrs_pkg::D_LRC;
                n_lrc    = 1'b1;
                n_state  = S_HEX_HI;
            end
            S_CR: begin
                if (i_sts.out_free) begin
                    o_cmd.op = mbrs_pkg::D_CR;
                    n_state  = S_LF;
                end
            end
            S_LF: begin
                if (i_sts.out_free) begin
                    o_cmd.op = mbrs_pkg::D_LF;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// File: hw/rtl/mbrs_dp.sv
// Datapath: frame assembly, register file, response byte source and output register.
module mbrs_dp #(
    parameter int REG_DEPTH   = 64,
    parameter int FRAME_DEPTH = 64,
    parameter int MAX_READ    = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbrs_pkg::t_cmd i_cmd,
    output mbrs_pkg::t_sts o_sts,
    input  logic           i_opcode,
    input  logic [7:0]     i_rx_char,
    input  logic [5:0]     i_meas_index,
    input  logic [15:0]    i_meas_value,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output logic           o_kind,
    output logic [7:0]     o_tx_char,
    output logic [5:0]     o_notice_index,
    output logic [15:0]    o_notice_value,
    output logic           o_last
);
    localparam int RA = $clog2(REG_DEPTH);
    localparam int FA = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int KW = $clog2(3 + 2 * MAX_READ);
    localparam int HDR_SZ = mbrs_pkg::HDR_LEN;

    logic           r_in_frame, r_half, r_err;
    logic [3:0]     r_hn;
    logic [CW-1:0]  r_bc;
    logic [7:0]     r_lrc;
    logic [7:0]     r_hdr [HDR_SZ];
    mbrs_pkg::t_rsp r_rsp;
    logic [FA-1:0]  r_bi;
    logic [KW-1:0]  r_k;
    logic [7:0]     r_sum, r_byte, r_hi;
    logic [REG_DEPTH-1:0] r_vld;
    logic           r_rd_vld;
    logic           r_ov, r_kind, r_last;
    logic [7:0]     r_tx;
    logic [5:0]     r_nidx;
    logic [15:0]    r_nval;

    mbrs_pkg::t_dop op;
    logic [4:0]     hv;
    logic           is_ctrl, is_colon, rx_ch, byte_we, meas_we, not_we, out_free;
    logic [7:0]     new_byte, f_rdata, src_byte;
    logic [15:0]    w_start, w_cnt, w_nidx, w_nval, reg_rdata, rd_word;
    logic [16:0]    w_end;
    logic           w_ok, w_n7, w_range, ok_rd, ok_w1, ok_wn;
    logic [FA-1:0]  f_raddr;
    logic [RA-1:0]  rf_waddr, rf_raddr;
    logic [15:0]    rf_wdata;
    logic [KW-1:0]  k_off;
    mbrs_pkg::t_rsp rsp;

    assign op       = i_cmd.op;
    assign hv       = mbrs_pkg::hex_val(i_rx_char);
    assign is_colon = i_rx_char == mbrs_pkg::CH_COLON;
    assign is_ctrl  = i_rx_char < mbrs_pkg::CH_SPACE || i_rx_char == mbrs_pkg::CH_DEL;
    assign rx_ch    = op == mbrs_pkg::D_RX && !i_opcode;
    assign new_byte = {r_hn, hv[3:0]};
    assign byte_we  = rx_ch && r_in_frame && !is_colon && !is_ctrl && hv[4] && r_half
                      && r_bc < CW'(FRAME_DEPTH);
    assign meas_we  = op == mbrs_pkg::D_RX && i_opcode && 9'(i_meas_index) < 9'(REG_DEPTH);
    assign not_we   = op == mbrs_pkg::D_NOTICE;

    assign w_start = {r_hdr[2], r_hdr[3]};
    assign w_cnt   = {r_hdr[4], r_hdr[5]};
    assign w_end   = {1'b0, w_start} + {1'b0, w_cnt};
    assign w_ok    = !r_err && !r_half && r_bc >= CW'(2) && r_lrc == 8'd0;
    assign w_n7    = r_bc == CW'(7);
    assign w_range = w_end <= 17'(REG_DEPTH);
    assign ok_rd   = w_n7 && w_cnt != 16'd0 && w_cnt <= 16'(MAX_READ) && w_range;
    assign ok_w1   = w_n7 && w_start < 16'(REG_DEPTH);
    assign ok_wn   = r_bc >= CW'(8) && w_cnt != 16'd0 && w_cnt <= 16'(mbrs_pkg::WRITE_LIMIT)
                     && w_range && 17'(r_hdr[6]) == {w_cnt[15:0], 1'b0}
                     && 9'(r_bc) == 9'd8 + {1'b0, r_hdr[6]};

    always_comb begin
        rsp = mbrs_pkg::RSP_NONE;
        if (w_ok) begin
            unique case (r_hdr[1])
                mbrs_pkg::FC_READ:   rsp = ok_rd ? mbrs_pkg::RSP_READ : mbrs_pkg::RSP_NONE;
                mbrs_pkg::FC_WRITE1: rsp = ok_w1 ? mbrs_pkg::RSP_WR1 : mbrs_pkg::RSP_NONE;
                mbrs_pkg::FC_WRITEN: rsp = ok_wn ? mbrs_pkg::RSP_WRN : mbrs_pkg::RSP_NONE;
                default:             rsp = mbrs_pkg::RSP_NONE;
            endcase
        end
    end

    // frame byte store
    assign f_raddr = FA'({r_bi, 1'b0}) + ((op == mbrs_pkg::D_FRD_HI) ? FA'(7) : FA'(8));

    mbrs_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame (
        .i_clk  (i_clk),
        .i_we   (byte_we),
        .i_waddr(r_bc[FA-1:0]),
        .i_wdata(new_byte),
        .i_re   (op == mbrs_pkg::D_FRD_HI || op == mbrs_pkg::D_FRD_LO),
        .i_raddr(f_raddr),
        .o_rdata(f_rdata)
    );

    // register file
    assign w_nidx   = (r_rsp == mbrs_pkg::RSP_WR1) ? w_start : w_start + 16'(r_bi);
    assign w_nval   = (r_rsp == mbrs_pkg::RSP_WR1) ? w_cnt : {r_hi, f_rdata};
    assign rf_waddr = not_we ? w_nidx[RA-1:0] : RA'(i_meas_index);
    assign rf_wdata = not_we ? w_nval : i_meas_value;
    assign k_off    = (r_k - KW'(3)) >> 1;
    assign rf_raddr = w_start[RA-1:0] + RA'(k_off);

    mbrs_ram #(.WIDTH(16), .DEPTH(REG_DEPTH)) u_regs (
        .i_clk  (i_clk),
        .i_we   (not_we || meas_we),
        .i_waddr(rf_waddr),
        .i_wdata(rf_wdata),
        .i_re   (op == mbrs_pkg::D_FETCH),
        .i_raddr(rf_raddr),
        .o_rdata(reg_rdata)
    );

    assign rd_word = r_rd_vld ? reg_rdata : 16'd0;

    always_comb begin
        src_byte = r_hdr[r_k[2:0]];
        if (r_rsp == mbrs_pkg::RSP_READ) begin
            if (r_k == KW'(0)) begin
                src_byte = r_hdr[0];
            end else if (r_k == KW'(1)) begin
                src_byte = mbrs_pkg::FC_READ;
            end else if (r_k == KW'(2)) begin
                src_byte = {w_cnt[6:0], 1'b0};
            end else begin
                src_byte = r_k[0] ? rd_word[15:8] : rd_word[7:0];
            end
        end
    end

    assign out_free = !r_ov || !i_out_stall;

    assign o_sts.frame_end = !i_opcode && r_in_frame && !is_colon && is_ctrl;
    assign o_sts.rsp       = rsp;
    assign o_sts.out_free  = out_free;
    assign o_sts.bw_last   = 16'(r_bi) + 16'd1 == w_cnt;
    assign o_sts.tx_last   = (r_rsp == mbrs_pkg::RSP_READ)
                             ? (16'(r_k) == 16'd2 + {w_cnt[14:0], 1'b0})
                             : (r_k == KW'(5));

    // frame receive control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_half     <= 1'b0;
            r_err      <= 1'b0;
            r_hn       <= 4'd0;
            r_bc       <= '0;
            r_lrc      <= 8'd0;
        end else if (rx_ch) begin
            if (is_colon) begin
                r_in_frame <= 1'b1;
                r_half     <= 1'b0;
                r_err      <= 1'b0;
                r_hn       <= 4'd0;
                r_bc       <= '0;
                r_lrc      <= 8'd0;
            end else if (r_in_frame) begin
                if (is_ctrl) begin
                    r_in_frame <= 1'b0;
                end else if (!hv[4]) begin
                    r_err <= 1'b1;
                end else if (!r_half) begin
                    r_hn   <= hv[3:0];
                    r_half <= 1'b1;
                end else begin
                    r_half <= 1'b0;
                    if (r_bc < CW'(FRAME_DEPTH)) begin
                        r_bc  <= r_bc + CW'(1);
                        r_lrc <= r_lrc + new_byte;
                    end else begin
                        r_err <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_we && r_bc < CW'(HDR_SZ)) begin
            r_hdr[r_bc[2:0]] <= new_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (not_we || meas_we) begin
            r_vld[rf_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp <= mbrs_pkg::RSP_NONE;
        end else if (op == mbrs_pkg::D_EVAL) begin
            r_rsp <= rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (op)
            mbrs_pkg::D_EVAL:   r_bi <= '0;
            mbrs_pkg::D_FRD_LO: r_hi <= f_rdata;
            mbrs_pkg::D_NOTICE: r_bi <= r_bi + FA'(1);
            mbrs_pkg::D_COLON: begin
                r_sum <= 8'd0;
                r_k   <= '0;
            end
            mbrs_pkg::D_FETCH:  r_rd_vld <= r_vld[rf_raddr];
            mbrs_pkg::D_LOAD:   r_byte <= src_byte;
            mbrs_pkg::D_LRC:    r_byte <= 8'd0 - r_sum;
            mbrs_pkg::D_HEX_LO: begin
                r_sum <= r_sum + r_byte;
                r_k   <= r_k + KW'(1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (op == mbrs_pkg::D_NOTICE || op == mbrs_pkg::D_COLON
                     || op == mbrs_pkg::D_HEX_HI || op == mbrs_pkg::D_HEX_LO
                     || op == mbrs_pkg::D_CR || op == mbrs_pkg::D_LF) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (op)
            mbrs_pkg::D_NOTICE: begin
                r_kind <= 1'b1;
                r_tx   <= 8'd0;
                r_nidx <= w_nidx[5:0];
                r_nval <= w_nval;
                r_last <= 1'b0;
            end
            mbrs_pkg::D_COLON, mbrs_pkg::D_HEX_HI, mbrs_pkg::D_HEX_LO,
            mbrs_pkg::D_CR, mbrs_pkg::D_LF: begin
                r_kind <= 1'b0;
                r_nidx <= 6'd0;
                r_nval <= 16'd0;
                r_last <= op == mbrs_pkg::D_LF;
                unique case (op)
                    mbrs_pkg::D_COLON:  r_tx <= mbrs_pkg::CH_COLON;
                    mbrs_pkg::D_HEX_HI: r_tx <= mbrs_pkg::hex_digit(r_byte[7:4]);
                    mbrs_pkg::D_HEX_LO: r_tx <= mbrs_pkg::hex_digit(r_byte[3:0]);
                    mbrs_pkg::D_CR:     r_tx <= mbrs_pkg::CH_CR;
                    default:            r_tx <= mbrs_pkg::CH_LF;
                endcase
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_ov;
    assign o_kind         = r_kind;
    assign o_tx_char      = r_tx;
    assign o_notice_index = r_nidx;
    assign o_notice_value = r_nval;
    assign o_last         = r_last;
endmodule

// File: hw/rtl/modbus_ascii_register_slave.sv
// Top level of the Modbus ASCII register slave.
// A frame end is followed by evaluation; a single write gives its notice and a block write
// reads each register's two data bytes from the frame store before its notice. A response
// sends ':', each byte (fetch, load, high and low hex digit), the LRC byte, CR and LF.
// The controller takes no new request until a frame's work is done; output stalls hold it.
// Reset is synchronous and active low; it clears the register file valid bits.
module modbus_ascii_register_slave #(
    parameter int REG_DEPTH   = 64,
    parameter int FRAME_DEPTH = 64,
    parameter int MAX_READ    = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_rx_char,
    input  logic [5:0]  i_meas_index,
    input  logic [15:0] i_meas_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_tx_char,
    output logic [5:0]  o_notice_index,
    output logic [15:0] o_notice_value,
    output logic        o_last
);
    mbrs_pkg::t_cmd cmd;
    mbrs_pkg::t_sts sts;

    mbrs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_sts     (sts),
        .o_in_stall(o_in_stall),
        .o_cmd     (cmd)
    );

    mbrs_dp #(
        .REG_DEPTH  (REG_DEPTH),
        .FRAME_DEPTH(FRAME_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_opcode),
        .i_rx_char     (i_rx_char),
        .i_meas_index  (i_meas_index),
        .i_meas_value  (i_meas_value),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_tx_char     (o_tx_char),
        .o_notice_index(o_notice_index),
        .o_notice_value(o_notice_value),
        .o_last        (o_last)
    );

    a_notice_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> !o_last)
        else $error("write notice marked last");

    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_tx_char == mbrs_pkg::CH_LF)
        else $error("final item is not LF");

    a_notice_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> o_tx_char == 8'd0)
        else $error("notice carries a character");
endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the Modbus ASCII register slave.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REGS = 64;
    localparam int FDEPTH = 64;
    localparam int RD_MAX = 12;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_char;
        logic [5:0]  notice_index;
        logic [15:0] notice_value;
        logic        last;
    } t_slave_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_opcode = 1'b0;
    logic [7:0]  i_rx_char = 8'h00;
    logic [5:0]  i_meas_index = 6'd0;
    logic [15:0] i_meas_value = 16'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_kind;
    logic [7:0]  o_tx_char;
    logic [5:0]  o_notice_index;
    logic [15:0] o_notice_value;
    logic        o_last;

    modbus_ascii_register_slave dut (.*);

    always #1 i_clk = ~i_clk;

    // shadow slave state
    logic [7:0]  sh_frame [FDEPTH];
    int          sh_count;
    bit          sh_in_frame;
    logic [3:0]  sh_hi;
    bit          sh_half;
    bit          sh_err;
    logic [7:0]  sh_lrc;
    logic [15:0] sh_regs [REGS];

    t_slave_out  expected_out [$];
    t_slave_out  step_out [$];
    int          errors = 0;
    bit          out_idle = 1'b1;

    function automatic logic [7:0] ascii_nib(input logic [3:0] v);
        return (v < 10) ? 8'd48 + v : 8'd55 + v;
    endfunction

    function automatic void push_char(input logic [7:0] c);
        t_slave_out r;
        r = '0;
        r.tx_char = c;
        step_out.push_back(r);
    endfunction

    function automatic void push_hex(input logic [7:0] b);
        push_char(ascii_nib(b[7:4]));
        push_char(ascii_nib(b[3:0]));
    endfunction

    function automatic void emit_reply(input logic [7:0] b [], input int n);
        logic [7:0] s;
        s = 8'd0;
        push_char(mbrs_pkg::CH_COLON);
        for (int i = 0; i < n; i++) begin
            push_hex(b[i]);
            s += b[i];
        end
        push_hex(8'd0 - s);
        push_char(mbrs_pkg::CH_CR);
        push_char(mbrs_pkg::CH_LF);
    endfunction

    function automatic void notice_write(input int idx, input logic [15:0] val);
        t_slave_out r;
        r = '0;
        sh_regs[idx] = val;
        r.kind = 1'b1;
        r.notice_index = idx[5:0];
        r.notice_value = val;
        step_out.push_back(r);
    endfunction

    function automatic void close_frame();
        logic [7:0] tx [];
        int start, cnt, n;
        n = sh_count;
        if (sh_err || sh_half || n < 2 || sh_lrc != 8'd0) return;
        start = (n > 3) ? {sh_frame[2], sh_frame[3]} : 0;
        cnt = (n > 5) ? {sh_frame[4], sh_frame[5]} : 0;
        case (sh_frame[1])
            mbrs_pkg::FC_READ: begin
                if (n != 7 || cnt == 0 || cnt > RD_MAX || start + cnt > REGS) return;
                tx = new[3 + 2 * cnt];
                tx[0] = sh_frame[0];
                tx[1] = mbrs_pkg::FC_READ;
                tx[2] = 8'(cnt * 2);
                for (int i = 0; i < cnt; i++) begin
                    tx[3 + 2 * i] = sh_regs[start + i][15:8];
                    tx[4 + 2 * i] = sh_regs[start + i][7:0];
                end
                emit_reply(tx, 3 + 2 * cnt);
            end
            mbrs_pkg::FC_WRITE1: begin
                if (n != 7 || start >= REGS) return;
                notice_write(start, 16'(cnt));
                tx = new[6];
                for (int i = 0; i < 6; i++) tx[i] = sh_frame[i];
                emit_reply(tx, 6);
            end
            mbrs_pkg::FC_WRITEN: begin
                if (n < 8 || cnt == 0 || cnt > mbrs_pkg::WRITE_LIMIT || start + cnt > REGS)
                    return;
                if (sh_frame[6] != cnt * 2 || n != 8 + sh_frame[6]) return;
                for (int i = 0; i < cnt; i++)
                    notice_write(start + i, {sh_frame[7 + 2 * i], sh_frame[8 + 2 * i]});
                tx = new[6];
                for (int i = 0; i < 6; i++) tx[i] = sh_frame[i];
                emit_reply(tx, 6);
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_request(input logic op, input logic [7:0] c,
                                            input logic [5:0] mi, input logic [15:0] mv);
        logic [4:0] hv;
        logic [7:0] b;
        step_out.delete();
        if (op) begin
            sh_regs[mi] = mv;
        end else if (c == mbrs_pkg::CH_COLON) begin
            sh_in_frame = 1; sh_count = 0; sh_hi = 0; sh_half = 0; sh_err = 0; sh_lrc = 0;
        end else if (sh_in_frame) begin
            if (c < mbrs_pkg::CH_SPACE || c == mbrs_pkg::CH_DEL) begin
                sh_in_frame = 0;
                close_frame();
            end else begin
                hv = 5'd0;
                if (c >= "0" && c <= "9") hv = {1'b1, 4'(c - "0")};
                else if (c >= "A" && c <= "F") hv = {1'b1, 4'(c - 8'd55)};
                else if (c >= "a" && c <= "f") hv = {1'b1, 4'(c - 8'd87)};
                if (!hv[4]) sh_err = 1;
                else if (!sh_half) begin
                    sh_hi = hv[3:0]; sh_half = 1;
                end else begin
                    sh_half = 0;
                    b = {sh_hi, hv[3:0]};
                    if (sh_count < FDEPTH) begin
                        sh_frame[sh_count] = b; sh_count++; sh_lrc += b;
                    end else sh_err = 1;
                end
            end
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) expected_out.push_back(step_out[i]);
    endfunction

    // valid stays high after an accept until the next request or an idle wait
    task automatic send_request(input logic op, input logic [7:0] c,
                                input logic [5:0] mi, input logic [15:0] mv);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_rx_char <= c;
        i_meas_index <= mi;
        i_meas_value <= mv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(op, c, mi, mv);
    endtask

    task automatic send_char(input logic [7:0] c);
        send_request(1'b0, c, 6'($urandom), 16'($urandom));
    endtask

    task automatic send_byte_hex(input logic [7:0] b, input bit lower);
        logic [7:0] h, l;
        h = ascii_nib(b[7:4]);
        l = ascii_nib(b[3:0]);
        if (lower && h >= "A") h = h + 8'd32;
        if (lower && l >= "A") l = l + 8'd32;
        send_char(h);
        send_char(l);
    endtask

    // sends ':' body LRC CR LF; bad_lrc corrupts the check byte
    task automatic send_frame(input logic [7:0] body [], input bit bad_lrc, input bit lower);
        logic [7:0] s;
        s = 8'd0;
        send_char(mbrs_pkg::CH_COLON);
        foreach (body[i]) begin
            send_byte_hex(body[i], lower);
            s += body[i];
        end
        send_byte_hex(8'd0 - s + (bad_lrc ? 8'd1 : 8'd0), lower);
        send_char(mbrs_pkg::CH_CR);
        send_char(mbrs_pkg::CH_LF);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_out.size() != 0 || !out_idle) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic void make_read(ref logic [7:0] f [], input int st, input int cnt);
        f = new[6];
        f[0] = 8'($urandom); f[1] = mbrs_pkg::FC_READ;
        f[2] = 8'(st >> 8); f[3] = 8'(st); f[4] = 8'(cnt >> 8); f[5] = 8'(cnt);
    endfunction

    function automatic void make_write1(ref logic [7:0] f [], input int st,
                                        input logic [15:0] v);
        f = new[6];
        f[0] = 8'($urandom); f[1] = mbrs_pkg::FC_WRITE1;
        f[2] = 8'(st >> 8); f[3] = 8'(st); f[4] = v[15:8]; f[5] = v[7:0];
    endfunction

    function automatic void make_writen(ref logic [7:0] f [], input int st, input int cnt);
        f = new[7 + 2 * cnt];
        f[0] = 8'($urandom); f[1] = mbrs_pkg::FC_WRITEN;
        f[2] = 8'(st >> 8); f[3] = 8'(st); f[4] = 8'(cnt >> 8); f[5] = 8'(cnt);
        f[6] = 8'(cnt * 2);
        for (int i = 0; i < 2 * cnt; i++) f[7 + i] = 8'($urandom);
    endfunction

    // response checker
    always @(posedge i_clk) begin
        t_slave_out got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_kind, o_tx_char, o_notice_index, o_notice_value, o_last};
            if (expected_out.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_out.pop_front();
                if (got.kind != want.kind || got.tx_char != want.tx_char ||
                    got.notice_index != want.notice_index ||
                    got.notice_value != want.notice_value || got.last != want.last) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // receiver stall: draws a wait per result, which is sometimes zero
    initial begin
        int w;
        @(posedge i_clk);
        forever begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (w != 0) begin
                i_out_stall <= 1'b1;
                out_idle = 1'b0;
                repeat (w) @(posedge i_clk);
                i_out_stall <= 1'b0;
                out_idle = 1'b1;
            end
            @(posedge i_clk);
            while (!(o_out_valid && !i_out_stall)) @(posedge i_clk);
        end
    end

    task automatic test_measure_and_read();
        logic [7:0] f [];
        send_request(1'b1, 8'h00, 6'd0, 16'hFFFF);
        send_request(1'b1, 8'hFF, 6'd63, 16'h0000);
        send_request(1'b1, 8'h00, 6'd62, 16'hA5C3);
        make_read(f, 52, RD_MAX);
        send_frame(f, 0, 0);
    endtask

    task automatic test_writes();
        logic [7:0] f [];
        make_write1(f, 63, 16'h1234);
        send_frame(f, 0, 0);
        make_writen(f, 10, 2);
        send_frame(f, 0, 1);
        wait_drained();
    endtask

    task automatic test_bad_frames();
        logic [7:0] f [];
        send_char(mbrs_pkg::CH_COLON); send_char("9");
        make_read(f, 0, 2);
        send_frame(f, 1, 0);
        f = new[2];
        f[0] = 8'h01; f[1] = 8'h07;
        send_frame(f, 0, 0);
        send_char(mbrs_pkg::CH_COLON); send_char(mbrs_pkg::CH_CR);
        send_char(mbrs_pkg::CH_COLON); send_char("1"); send_char("2"); send_char("3");
        send_char(mbrs_pkg::CH_CR);
        send_char(mbrs_pkg::CH_COLON); send_char("G"); send_char("0");
        send_char(mbrs_pkg::CH_DEL);
        send_char(8'h80); send_char(8'h0D); send_char("A");
        wait_drained();
    endtask

    task automatic test_random();
        for (int n = 0; n < 10; n++) begin
            if ($urandom_range(0, 1) == 0) begin
                send_request(1'b1, 8'($urandom), 6'($urandom), 16'($urandom));
            end else begin
                send_char(8'($urandom));
            end
        end
        send_char(mbrs_pkg::CH_CR);
    endtask

    initial begin
        foreach (sh_regs[i]) sh_regs[i] = 16'd0;
        foreach (sh_frame[i]) sh_frame[i] = 8'd0;
        sh_count = 0; sh_in_frame = 0; sh_hi = 0; sh_half = 0; sh_err = 0; sh_lrc = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_measure_and_read();
        test_writes();
        test_bad_frames();
        test_random();
        wait_drained();
        repeat (400) @(posedge i_clk);
        if (errors == 0 && expected_out.size() == 0) begin
            $display("modbus_ascii_register_slave verification clean");
        end else begin
            $display("modbus_ascii_register_slave verification failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("modbus_ascii_register_slave verification failed");
        $finish;
    end
endmodule
